// ----- rtl/sbv_pkg.sv -----
// Shared types, constants and arithmetic helpers for the vertical Sobel filter.
package sbv_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SIZE_W     = 9;
  localparam int unsigned COORD_W    = 8;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(3);

  // Output queue: at most four results per pixel
  localparam int unsigned PUSH_MAX = 4;
  localparam int unsigned QDEPTH   = 8;

  typedef struct packed {
    logic [PIX_W-1:0]   value;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               frame_end;
  } sbv_res_t;

  // Weighted 1-2-1 sum of three pixels
  function automatic logic [PIX_W+1:0] win3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    win3 = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

  // Difference of two window sums, clamped to 0..255
  function automatic logic [PIX_W-1:0] grad(input logic [PIX_W+1:0] lo,
                                            input logic [PIX_W+1:0] hi);
    logic signed [PIX_W+2:0] d;
    d = $signed({1'b0, lo}) - $signed({1'b0, hi});
    if (d < 0) begin
      grad = '0;
    end else if (d > 255) begin
      grad = '1;
    end else begin
      grad = d[PIX_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/sbv_if.sv -----
// Handshake interfaces: pixel input, result output and size configuration.
interface sbv_pix_if;
  import sbv_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface sbv_res_if;
  import sbv_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   value;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               frame_end;
  modport source (output valid, output value, output out_row, output out_col,
                  output frame_end, input ready);
  modport sink   (input valid, input value, input out_row, input out_col,
                  input frame_end, output ready);
endinterface

interface sbv_cfg_if;
  import sbv_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] image_size;
  modport source (output valid, output image_size, input ready);
  modport sink   (input valid, input image_size, output ready);
endinterface

// ----- rtl/sbv_ram.sv -----
// Generic simple dual-port RAM with registered read.
module sbv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/sbv_out_queue.sv -----
// Result queue: takes up to four results per cycle, delivers one per beat.
module sbv_out_queue import sbv_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [PUSH_MAX-1:0]         push_vld,
  input  sbv_res_t [PUSH_MAX-1:0]     push_ent,
  input  logic                        pop,
  output sbv_res_t                    head,
  output logic [$clog2(QDEPTH+1)-1:0] count
);

  localparam int unsigned PW  = $clog2(QDEPTH);
  localparam int unsigned CNW = $clog2(QDEPTH+1);
  localparam int unsigned OW  = $clog2(PUSH_MAX+1);

  sbv_res_t         mem_r [QDEPTH];
  logic [PW-1:0]    head_r, tail_r;
  logic [CNW-1:0]   count_r;
  logic [OW-1:0]    off [PUSH_MAX];
  logic [OW-1:0]    push_n;

  // Slot offset of each valid result among those pushed this cycle
  always_comb begin
    push_n = '0;
    for (int k = 0; k < PUSH_MAX; k++) begin
      off[k] = push_n;
      push_n = push_n + OW'(push_vld[k]);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    for (int k = 0; k < PUSH_MAX; k++) begin
      if (push_vld[k]) begin
        mem_r[tail_r + PW'(off[k])] <= push_ent[k];
      end
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      tail_r  <= tail_r + PW'(push_n);
      head_r  <= head_r + PW'(pop);
      count_r <= count_r + CNW'(push_n) - CNW'(pop);
    end
  end

  assign head  = mem_r[head_r];
  assign count = count_r;

  // Pushes never overrun the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ((CNW+1)'(count_r) + (CNW+1)'(push_n) <= (CNW+1)'(QDEPTH)))
    else $error("result queue overflow");

  // No beat leaves an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("result queue underflow");

  // Fill count stays within the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNW'(QDEPTH)))
    else $error("result queue count out of range");

endmodule

// ----- rtl/sobel_vertical_gradient_3x3_top.sv -----
// Top level of the 3x3 vertical-gradient Sobel filter.
//
// Pixels of a square image (side image_size, 3..MAX_SIZE) enter in raster
// order, one per beat, and the block accepts a pixel every clock cycle while
// the result queue has room and results drain at one per cycle. Each pixel
// passes an input register (line store read) and a result stage (window
// sums, clamp, line store write); the result stage writes its results into
// the output queue, from whose head they leave. Result for centre (r-1,c-1)
// follows pixel (r,c); the last pixel of a row adds the row's last column,
// and the last row adds its own results, up to four per pixel. An 8-entry
// result queue absorbs these; while it is short of room for a further four
// results the input stalls, so the last row runs slower, limited by the
// single result beat per cycle. Writing image_size restarts the frame at
// (0,0). No clearing pass is needed after reset: a line entry is only used
// once written in the current frame.
module sobel_vertical_gradient_3x3_top import sbv_pkg::*; #(
  parameter int unsigned MAX_SIZE = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  sbv_pix_if.sink   in_pix,
  sbv_res_if.source out_res,
  sbv_cfg_if.sink   cfg_wr
);

  localparam int unsigned CW  = $clog2(MAX_SIZE);
  localparam int unsigned NW  = ($clog2(MAX_SIZE+1) > SIZE_W) ? $clog2(MAX_SIZE+1) : SIZE_W;
  localparam int unsigned XW  = (CW > COORD_W) ? CW : COORD_W;
  localparam int unsigned QCW = $clog2(QDEPTH+1);
  localparam int unsigned OW  = $clog2(PUSH_MAX+1);

  // ---------------- configuration and position counters ----------------
  logic [SIZE_W-1:0] size_r;
  logic [CW-1:0]     row_r, col_r;
  logic [NW-1:0]     sz, n_eff, nm1;
  logic [CW-1:0]     r_eff, c_eff, row_nxt, col_nxt;
  logic              last_row, last_col, accept;

  assign cfg_wr.ready = 1'b1;

  // Clamp the size register into 3..MAX_SIZE
  always_comb begin
    sz = NW'(size_r);
    if (sz < NW'(SIZE_MIN)) begin
      n_eff = NW'(SIZE_MIN);
    end else if (sz > NW'(MAX_SIZE)) begin
      n_eff = NW'(MAX_SIZE);
    end else begin
      n_eff = sz;
    end
    nm1 = n_eff - NW'(1);
  end

  // Position of this pixel and of the next
  always_comb begin
    r_eff = row_r;
    c_eff = col_r;
    if (NW'(row_r) >= n_eff || NW'(col_r) >= n_eff) begin
      r_eff = '0;
      c_eff = '0;
    end
    last_row = (NW'(r_eff) == nm1);
    last_col = (NW'(c_eff) == nm1);
    col_nxt  = c_eff + CW'(1);
    row_nxt  = r_eff;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : r_eff + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
      row_r  <= '0;
      col_r  <= '0;
    end else if (cfg_wr.valid) begin
      size_r <= cfg_wr.image_size;
      row_r  <= '0;
      col_r  <= '0;
    end else if (accept) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  // ---------------- input register ----------------
  logic               s1_valid_r;
  logic [PIX_W-1:0]   s1_pix_r;
  logic [CW-1:0]      s1_col_r;
  logic               s1_rge1_r, s1_rge2_r, s1_cge1_r, s1_lrow_r, s1_lcol_r;
  logic [COORD_W-1:0] s1_row_r, s1_rowm1_r, s1_colm1_r, s1_nm1_r;
  logic [XW-1:0]      r_x, rm1_x, cm1_x, nm1_x;

  assign r_x   = XW'(r_eff);
  assign rm1_x = XW'(r_eff - CW'(1));
  assign cm1_x = XW'(c_eff - CW'(1));
  assign nm1_x = XW'(nm1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= in_pix.pixel;
      s1_col_r   <= c_eff;
      s1_rge1_r  <= (r_eff != '0);
      s1_rge2_r  <= (r_eff > CW'(1));
      s1_cge1_r  <= (c_eff != '0);
      s1_lrow_r  <= last_row;
      s1_lcol_r  <= last_col;
      s1_row_r   <= r_x[COORD_W-1:0];
      s1_rowm1_r <= rm1_x[COORD_W-1:0];
      s1_colm1_r <= cm1_x[COORD_W-1:0];
      s1_nm1_r   <= nm1_x[COORD_W-1:0];
    end
  end

  // ---------------- line stores ----------------
  logic [PIX_W-1:0] newer_rd, older_rd, n0, o0;

  assign n0 = s1_rge1_r ? newer_rd : '0;
  assign o0 = s1_rge2_r ? older_rd : '0;

  sbv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIZE)) u_line_newer (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .re    (accept),
    .raddr (c_eff),
    .rdata (newer_rd)
  );

  sbv_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIZE)) u_line_older (
    .clk   (clk),
    .we    (s1_valid_r && s1_rge1_r),
    .waddr (s1_col_r),
    .wdata (n0),
    .re    (accept),
    .raddr (c_eff),
    .rdata (older_rd)
  );

  // ---------------- column taps ----------------
  logic [PIX_W-1:0] pp1_r, pp2_r, o1_r, o2_r, n1_r, n2_r;
  logic [PIX_W-1:0] pp1, pp2, o1, o2, n1, n2;

  // Taps read as zero at the left edge
  assign pp1 = s1_cge1_r ? pp1_r : '0;
  assign pp2 = s1_cge1_r ? pp2_r : '0;
  assign o1  = s1_cge1_r ? o1_r  : '0;
  assign o2  = s1_cge1_r ? o2_r  : '0;
  assign n1  = s1_cge1_r ? n1_r  : '0;
  assign n2  = s1_cge1_r ? n2_r  : '0;

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      pp2_r <= pp1;
      pp1_r <= s1_pix_r;
      o2_r  <= o1;
      o1_r  <= o0;
      n2_r  <= n1;
      n1_r  <= n0;
    end
  end

  // ---------------- result stage ----------------
  logic [PUSH_MAX-1:0]     push_vld;
  sbv_res_t [PUSH_MAX-1:0] push_ent;
  logic [OW-1:0]           s1_n;
  logic [QCW-1:0]          q_count;
  sbv_res_t                q_head;
  logic                    pop;

  always_comb begin
    push_vld[0] = s1_valid_r && s1_rge1_r && s1_cge1_r;
    push_vld[1] = s1_valid_r && s1_rge1_r && s1_lcol_r;
    push_vld[2] = s1_valid_r && s1_lrow_r && s1_cge1_r;
    push_vld[3] = s1_valid_r && s1_lrow_r && s1_lcol_r;

    // Centre one row up, one column left
    push_ent[0].value     = grad(win3(pp2, pp1, s1_pix_r), win3(o2, o1, o0));
    push_ent[0].out_row   = s1_rowm1_r;
    push_ent[0].out_col   = s1_colm1_r;
    push_ent[0].frame_end = 1'b0;
    // Right edge of the row above
    push_ent[1].value     = grad(win3(pp1, s1_pix_r, '0), win3(o1, o0, '0));
    push_ent[1].out_row   = s1_rowm1_r;
    push_ent[1].out_col   = s1_nm1_r;
    push_ent[1].frame_end = 1'b0;
    // Bottom row: lower window is outside the image
    push_ent[2].value     = grad('0, win3(n2, n1, n0));
    push_ent[2].out_row   = s1_row_r;
    push_ent[2].out_col   = s1_colm1_r;
    push_ent[2].frame_end = 1'b0;
    // Bottom right corner closes the frame
    push_ent[3].value     = grad('0, win3(n1, n0, '0));
    push_ent[3].out_row   = s1_row_r;
    push_ent[3].out_col   = s1_nm1_r;
    push_ent[3].frame_end = 1'b1;

    s1_n = '0;
    for (int k = 0; k < PUSH_MAX; k++) begin
      s1_n = s1_n + OW'(push_vld[k]);
    end
  end

  // Accept only with room for the worst case of the next pixel
  assign in_pix.ready = ((QCW+1)'(q_count) + (QCW+1)'(s1_n))
                        <= (QCW+1)'(QDEPTH - PUSH_MAX);
  assign accept = in_pix.valid && in_pix.ready;

  sbv_out_queue u_out_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_vld (push_vld),
    .push_ent (push_ent),
    .pop      (pop),
    .head     (q_head),
    .count    (q_count)
  );

  assign out_res.valid     = (q_count != '0);
  assign out_res.value     = q_head.value;
  assign out_res.out_row   = q_head.out_row;
  assign out_res.out_col   = q_head.out_col;
  assign out_res.frame_end = q_head.frame_end;
  assign pop               = out_res.valid && out_res.ready;

  // The closing result sits on the diagonal corner
  a_frame_end_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.frame_end) |-> (out_res.out_row == out_res.out_col))
    else $error("frame end off the corner");

  // The last pixel of a frame wraps the counters to the origin
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_row && last_col) |=> (row_r == '0 && col_r == '0))
    else $error("counters did not wrap at frame end");

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.ready) |=> (out_res.valid &&
      $stable({out_res.value, out_res.out_row, out_res.out_col, out_res.frame_end})))
    else $error("result beat changed while stalled");

endmodule
